/* hw/rtl/lesm_pkg.sv */
// lesm_pkg: constants and types for the largest empty square map unit
// depends on nothing; used by largest_empty_square_map_unit and its bench
`timescale 1ns / 1ps

package lesm_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;

	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SIZE_W = 11;
	localparam int CNT_W  = 11;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [BYTE_W-1:0] OBSTACLE_BYTE = 8'h6F;

	// register indexes, decoded from paddr[2]
	localparam logic REG_COLUMN_COUNT = 1'b0;
	localparam logic REG_ROW_COUNT    = 1'b1;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;

	// clamp a register count to 1..max and return count - 1
	function automatic logic [31:0] clamp_m1(input count_t v, input int max);
		logic [31:0] r;
		begin
			if (v == '0) begin
				r = 32'd0;
			end else if ({21'd0, v} > 32'(max)) begin
				r = 32'(max) - 32'd1;
			end else begin
				r = {21'd0, v} - 32'd1;
			end
			return r;
		end
	endfunction

endpackage

/* hw/rtl/largest_empty_square_map_unit.sv */
// largest_empty_square_map_unit: maximal empty square over a reverse raster map stream
// depends on lesm_pkg; holds the line store memory and the apb registers
// two register stages, stage one and the output register; throughput one cell per
// cycle unless out_ready stalls, set by one line store read and one write per cell
// reset: counts go to 1024, positions and neighbor values to zero; the line store is
// not cleared, every entry read is written by the previous row first
`timescale 1ns / 1ps

module largest_empty_square_map_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lesm_pkg::ADDR_W-1:0]  paddr,
	input  logic [lesm_pkg::DATA_W-1:0]  pwdata,
	output logic [lesm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lesm_pkg::BYTE_W-1:0]  cell_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lesm_pkg::SIZE_W-1:0]  square_size,
	output logic                         last_cell
);
	import lesm_pkg::*;

	count_t column_count_q, row_count_q;
	col_t   cols_m1, col_q;
	row_t   rows_m1, row_q;
	logic   cfg_wr;

	size_t  mem [MAX_COLUMNS];

	logic   v_s1, obst_s1, edge_s1, row_end_s1, map_end_s1;
	col_t   addr_s1;
	size_t  rd_s1;
	size_t  right_q, diag_q;
	logic   out_valid_q, last_q;
	size_t  size_q;

	logic   accept, adv, row_end, map_end;
	size_t  min_a, min_b, v_new;

	// apb register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		case (paddr[2])
			REG_COLUMN_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, column_count_q};
			REG_ROW_COUNT:    prdata = {{(DATA_W-CNT_W){1'b0}}, row_count_q};
			default:          prdata = '0;
		endcase
	end

	assign cols_m1 = COL_W'(clamp_m1(column_count_q, MAX_COLUMNS));
	assign rows_m1 = ROW_W'(clamp_m1(row_count_q, MAX_ROWS));

	// handshake: stage one moves on when the output register is free
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign row_end  = (col_q == cols_m1);
	assign map_end  = row_end && (row_q == rows_m1);

	// recurrence on stage one data
	always_comb begin
		min_a = (right_q < rd_s1) ? right_q : rd_s1;
		min_b = (min_a < diag_q) ? min_a : diag_q;
		if (obst_s1) begin
			v_new = '0;
		end else if (edge_s1) begin
			v_new = SIZE_W'(1);
		end else begin
			v_new = min_b + SIZE_W'(1);
		end
	end

	// line store: read on request, write back when stage one moves on;
	// a same-column read and write only meet for one-column maps, where the read is unused
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[col_q];
		end
		if (adv) begin
			mem[addr_s1] <= v_new;
		end
	end

	// stage one and output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			obst_s1    <= (cell_byte == OBSTACLE_BYTE);
			edge_s1    <= (col_q == '0) || (row_q == '0);
			row_end_s1 <= row_end;
			map_end_s1 <= map_end;
			addr_s1    <= col_q;
		end
		if (adv) begin
			size_q <= v_new;
			last_q <= map_end_s1;
		end
	end

	// control state, registers and neighbor values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= CNT_W'(MAX_COLUMNS);
			row_count_q    <= CNT_W'(MAX_ROWS);
			col_q          <= '0;
			row_q          <= '0;
			right_q        <= '0;
			diag_q         <= '0;
			v_s1           <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				right_q <= row_end_s1 ? '0 : v_new;
				diag_q  <= row_end_s1 ? '0 : rd_s1;
			end
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= map_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (cfg_wr) begin
				case (paddr[2])
					REG_COLUMN_COUNT: column_count_q <= pwdata[CNT_W-1:0];
					REG_ROW_COUNT:    row_count_q    <= pwdata[CNT_W-1:0];
					default:          column_count_q <= column_count_q;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				right_q <= '0;
				diag_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign square_size = size_q;
	assign last_cell   = last_q;

	// checks
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= cols_m1) else $error("column position beyond row end");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= rows_m1) else $error("row position beyond map end");
	a_obst_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && obst_s1 |=> out_valid && (square_size == '0))
		else $error("obstacle cell gave a nonzero size");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s1)) else $error("result without a request in stage one");

endmodule

/* tb/sv/tb_largest_empty_square_map_unit.sv */
// tb_largest_empty_square_map_unit: self-checking bench for the largest empty square map unit
// depends on lesm_pkg and largest_empty_square_map_unit; drives cells and apb writes,
// predicts each square size and last-cell flag and checks every result in order
`timescale 1ns / 1ps

module tb_largest_empty_square_map_unit;
	import lesm_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int RANDOM_CELLS   = 650;

	typedef struct packed {
		size_t side;
		logic  last;
	} square_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   cell_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SIZE_W-1:0]   square_size;
	logic                last_cell;

	// mirror of the map geometry and the recurrence state
	count_t      col_count_reg = count_t'(MAX_COLUMNS);
	count_t      row_count_reg = count_t'(MAX_ROWS);
	size_t       below_row [MAX_COLUMNS];
	size_t       right_side = '0;
	size_t       diag_side  = '0;
	int unsigned col_pos    = 0;
	int unsigned row_pos    = 0;

	square_t     expected_squares[$];
	int unsigned errors         = 0;
	int unsigned send_idle_pct  = 23;
	int unsigned recv_idle_pct  = 63;

	always #5 clk = ~clk;

	largest_empty_square_map_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cell_byte   (cell_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.square_size (square_size),
		.last_cell   (last_cell)
	);

	// effective count: zero means one, above the maximum means the maximum
	function automatic int unsigned count_in_use(input count_t v, input int unsigned limit);
		if (v == '0) begin
			return 1;
		end
		if (v > limit) begin
			return limit;
		end
		return v;
	endfunction

	function automatic int unsigned cells_in_map();
		return count_in_use(col_count_reg, MAX_COLUMNS) * count_in_use(row_count_reg, MAX_ROWS);
	endfunction

	function automatic void restart_map();
		right_side = '0;
		diag_side  = '0;
		col_pos    = 0;
		row_pos    = 0;
	endfunction

	// one step of 1 + min(right, below, diagonal) over the reverse raster order
	function automatic void predict_square(input logic [BYTE_W-1:0] b);
		int unsigned ncols, nrows, c, r;
		size_t       below, v, m;
		logic        row_end, map_end;
		ncols = count_in_use(col_count_reg, MAX_COLUMNS);
		nrows = count_in_use(row_count_reg, MAX_ROWS);
		c = (col_pos >= ncols) ? ncols - 1 : col_pos;
		r = (row_pos >= nrows) ? nrows - 1 : row_pos;
		below = below_row[c];
		if (b == OBSTACLE_BYTE) begin
			v = '0;
		end else if (r == 0 || c == 0) begin
			v = size_t'(1);
		end else begin
			m = right_side;
			if (below < m) begin
				m = below;
			end
			if (diag_side < m) begin
				m = diag_side;
			end
			v = m + size_t'(1);
		end
		diag_side   = below;
		right_side  = v;
		below_row[c] = v;
		row_end = (c + 1 >= ncols);
		map_end = row_end && (r + 1 >= nrows);
		if (row_end) begin
			col_pos    = 0;
			right_side = '0;
			diag_side  = '0;
			row_pos    = map_end ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
		expected_squares.push_back('{v, map_end});
	endfunction

	// result side: random stalls, compare with the oldest expectation
	always @(posedge clk) begin : check_results
		square_t exp_sq;
		if (arst_n && out_valid && out_ready) begin
			if (expected_squares.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual square_size %0d last_cell %0d",
					$time, square_size, last_cell);
				errors++;
			end else begin
				exp_sq = expected_squares.pop_front();
				if (square_size !== exp_sq.side) begin
					$display("%0t: square_size expected %0d actual %0d",
						$time, exp_sq.side, square_size);
					errors++;
				end
				if (last_cell !== exp_sq.last) begin
					$display("%0t: last_cell expected %0d actual %0d",
						$time, exp_sq.last, last_cell);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one request on the cell channel, with optional idle cycles ahead of it
	task automatic send_cell(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cell_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_square(b);
	endtask

	// random cells, obstacle_pct percent of them obstacles, plus random bytes that hit the obstacle byte
	task automatic send_map_cells(input int unsigned n, input int unsigned obstacle_pct);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < obstacle_pct) begin
				send_cell(OBSTACLE_BYTE);
			end else begin
				send_cell(BYTE_W'($urandom_range(255)));
			end
		end
	endtask

	// stop sending and wait until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_squares.size() != 0) begin
			@(posedge clk);
		end
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	// apb write: setup then access; a write restarts the map
	task automatic write_reg(input logic reg_sel, input logic [DATA_W-1:0] data);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_COLUMN_COUNT) begin
			col_count_reg = data[CNT_W-1:0];
		end else begin
			row_count_reg = data[CNT_W-1:0];
		end
		restart_map();
	endtask

	task automatic set_map(input logic [DATA_W-1:0] cols, input logic [DATA_W-1:0] rows);
		write_reg(REG_COLUMN_COUNT, cols);
		write_reg(REG_ROW_COUNT, rows);
	endtask

	// counts after reset: start of the bottom row of a full size map
	task automatic test_reset_defaults();
		send_map_cells(24, 10);
	endtask

	// one cell maps: obstacle, lowest and highest byte
	task automatic test_single_cell();
		set_map(1, 1);
		send_cell(OBSTACLE_BYTE);
		send_cell(8'h00);
		send_cell(8'hFF);
	endtask

	// bytes one bit away from the obstacle byte are empty; then the obstacle byte and three other bytes
	task automatic test_obstacle_byte();
		set_map(4, 3);
		for (int k = 0; k < BYTE_W; k++) begin
			send_cell(OBSTACLE_BYTE ^ (8'h01 << k));
		end
		send_cell(OBSTACLE_BYTE);
		send_cell(8'h20);
		send_cell(8'h2E);
		send_cell(8'h4F);
	endtask

	// a rewrite in the middle of a map starts over at the bottom right
	task automatic test_restart_mid_map();
		set_map(6, 5);
		send_map_cells(13, 0);
		write_reg(REG_ROW_COUNT, 5);
		send_map_cells(30, 0);
	endtask

	// maps back to back with no write in between
	task automatic test_map_wrap();
		set_map(3, 2);
		send_map_cells(6, 0);
		send_map_cells(6, 20);
		send_map_cells(6, 0);
	endtask

	// single column maps back to back; zero column count means one
	task automatic test_row_extremes();
		set_map(32'hFFFF_F800, 37);
		send_map_cells(2 * 37 + 3, 10);
	endtask

	// single row of the maximum width; counts above the maximum are clamped
	task automatic test_column_extremes();
		set_map(32'h0000_07FF, 32'h0000_0000);
		send_map_cells(MAX_COLUMNS + 3, 10);
	endtask

	function automatic logic [DATA_W-1:0] random_count();
		int unsigned n;
		case ($urandom_range(19))
			0:       n = 0;
			1:       n = $urandom_range(48, 17);
			default: n = $urandom_range(16, 1);
		endcase
		return {21'($urandom), 11'(n)};
	endfunction

	// random maps, mostly complete, some cut short by a register write
	task automatic test_random_maps();
		int unsigned sent, n, density;
		logic        need_write;
		sent = 0;
		need_write = 1'b1;
		while (sent < RANDOM_CELLS) begin
			case (sent * 3 / RANDOM_CELLS)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (need_write || $urandom_range(3) != 0) begin
				set_map(random_count(), random_count());
			end
			case ($urandom_range(3))
				0:       density = 0;
				1:       density = 5;
				2:       density = 20;
				default: density = 60;
			endcase
			n = cells_in_map();
			need_write = 1'b0;
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(n, 1);
				need_write = 1'b1;
			end
			// keep the total near the cell budget
			if (n > RANDOM_CELLS - sent) begin
				n = RANDOM_CELLS - sent;
				need_write = 1'b1;
			end
			send_map_cells(n, density);
			sent += n;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_single_cell();
		test_obstacle_byte();
		test_restart_mid_map();
		test_map_wrap();
		test_row_extremes();
		test_column_extremes();
		test_random_maps();
		drain_results();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
